// ===== rtl/core/dcgp_pkg.sv =====
// ----------------------------------------------------------------------------
// dcgp_pkg
// Shared types for the degree-clustered graph stream parser.
// ----------------------------------------------------------------------------
package dcgp_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned PartW   = 24;
    localparam int unsigned BposW   = 2;

    typedef enum logic [2:0] {
        PH_DEGREE = 3'd0,
        PH_COUNT  = 3'd1,
        PH_SOURCE = 3'd2,
        PH_TARGET = 3'd3,
        PH_WEIGHT = 3'd4
    } phase_t;

    typedef struct packed {
        logic [WordW-1:0] from_vertex;
        logic [WordW-1:0] to_vertex;
        logic [ByteW-1:0] edge_weight;
    } edge_t;

endpackage

// ===== rtl/core/dcgp_parser.sv =====
// ----------------------------------------------------------------------------
// dcgp_parser
// Parse state and next-state logic; one byte per step, flags weight bytes.
// ----------------------------------------------------------------------------
module dcgp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    output logic                  edge_hit,
    output dcgp_pkg::edge_t       edge_data
);
    import dcgp_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic [BposW-1:0]   bpos_reg,    bpos_next;
    logic [PartW-1:0]   part_reg,    part_next;
    logic [WordW-1:0]   degree_reg,  degree_next;
    logic [WordW-1:0]   vleft_reg,   vleft_next;
    logic [WordW-1:0]   eleft_reg,   eleft_next;
    logic [WordW-1:0]   source_reg,  source_next;
    logic [WordW-1:0]   target_reg,  target_next;

    logic [WordW-1:0]   word;
    logic               last_vertex;

    assign word        = {data_byte, part_reg};
    // vertices_left - 1 == 0
    assign last_vertex = (vleft_reg == WordW'(1));

    assign edge_hit              = (phase_reg == PH_WEIGHT);
    assign edge_data.from_vertex = source_reg;
    assign edge_data.to_vertex   = target_reg;
    assign edge_data.edge_weight = data_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        bpos_next   = bpos_reg;
        part_next   = part_reg;
        degree_next = degree_reg;
        vleft_next  = vleft_reg;
        eleft_next  = eleft_reg;
        source_next = source_reg;
        target_next = target_reg;

        if (phase_reg == PH_WEIGHT)
        begin
            eleft_next = eleft_reg - WordW'(1);
            if (eleft_reg != WordW'(1))
            begin
                phase_next = PH_TARGET;
            end
            else
            begin
                vleft_next = vleft_reg - WordW'(1);
                phase_next = last_vertex ? PH_DEGREE : PH_SOURCE;
            end
        end
        else if (bpos_reg != 2'd3)
        begin
            // low bytes of a little-endian word
            case (bpos_reg)
                2'd0:    part_next[7:0]   = data_byte;
                2'd1:    part_next[15:8]  = data_byte;
                default: part_next[23:16] = data_byte;
            endcase
            bpos_next = bpos_reg + 2'd1;
        end
        else
        begin
            bpos_next = '0;
            part_next = '0;
            unique case (phase_reg)
                PH_COUNT:
                begin
                    vleft_next = word;
                    phase_next = (word == '0) ? PH_DEGREE : PH_SOURCE;
                end
                PH_SOURCE:
                begin
                    source_next = word;
                    eleft_next  = degree_reg;
                    if (degree_reg == '0)
                    begin
                        vleft_next = vleft_reg - WordW'(1);
                        phase_next = last_vertex ? PH_DEGREE : PH_SOURCE;
                    end
                    else
                    begin
                        phase_next = PH_TARGET;
                    end
                end
                PH_TARGET:
                begin
                    target_next = word;
                    phase_next  = PH_WEIGHT;
                end
                default:
                begin
                    degree_next = word;
                    phase_next  = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DEGREE;
            bpos_reg   <= '0;
            part_reg   <= '0;
            degree_reg <= '0;
            vleft_reg  <= '0;
            eleft_reg  <= '0;
            source_reg <= '0;
            target_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bpos_reg   <= bpos_next;
            part_reg   <= part_next;
            degree_reg <= degree_next;
            vleft_reg  <= vleft_next;
            eleft_reg  <= eleft_next;
            source_reg <= source_next;
            target_reg <= target_next;
        end
    end

endmodule

// ===== rtl/core/degree_clustered_graph_parser_unit.sv =====
// ----------------------------------------------------------------------------
// degree_clustered_graph_parser_unit
// Byte-wise parser for a degree-clustered graph stream, one edge per weight.
// ----------------------------------------------------------------------------
//  channel | signals                               | request
//  --------+---------------------------------------+------------------------
//  in      | in_valid, in_ready, data_byte         | one stream byte
//  out     | out_valid, out_ready, from_vertex,    | one decoded edge
//          | to_vertex, edge_weight                |
//
//  one byte per cycle while the output is not stalled; a byte goes to the edge
//  through the input register, then parse logic into the output register.
//  rst_n clears the parse state to expecting a degree word, both registers empty.
//  a stalled output holds the edge and stops parsing; the one-byte input
//  register still takes a byte while it is empty, then in_ready drops.
// ----------------------------------------------------------------------------
module degree_clustered_graph_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] from_vertex,
    output logic [31:0] to_vertex,
    output logic [7:0]  edge_weight
);
    import dcgp_pkg::*;

    logic               in_valid_reg,  in_valid_next;
    logic [ByteW-1:0]   in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    edge_t              edge_reg;

    logic               advance;
    logic               edge_hit;
    edge_t              edge_data;

    // byte moves into the parser only when the output slot can take an edge
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dcgp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .edge_hit  (edge_hit),
        .edge_data (edge_data)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && edge_hit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= data_byte;
        if (advance && edge_hit)
            edge_reg <= edge_data;
    end

    assign out_valid   = out_valid_reg;
    assign from_vertex = edge_reg.from_vertex;
    assign to_vertex   = edge_reg.to_vertex;
    assign edge_weight = edge_reg.edge_weight;

endmodule
